FILE: src/pcvf_pkg.sv
package pcvf_pkg;

   localparam int CHANNELS     = 3;
   localparam int CSR_IDX_W    = 4;
   localparam int CSR_DATA_W   = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_GATE_RATIO = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_RATE = 4'd1;

   localparam logic [9:0]  GATE_RATIO_RESET = 10'd307;
   localparam logic [23:0] NOISE_RATE_RESET = 24'd1678;

   // Last counter value of each serial phase.
   localparam logic [5:0] LAST_REDUCE  = 6'd11;
   localparam logic [5:0] LAST_GROWTH  = 6'd31;
   localparam logic [5:0] LAST_SQUARE  = 6'd23;
   localparam logic [5:0] LAST_PRODUCT = 6'd47;
   localparam logic [5:0] LAST_DIVIDE  = 6'd47;
   localparam logic [5:0] LAST_ROOT    = 6'd23;

   typedef enum logic [1:0] {
      STATUS_REJECT = 2'd0,
      STATUS_FIRST  = 2'd1,
      STATUS_FUSED  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_READ,
      ST_DECIDE,
      ST_GROWTH,
      ST_LOAD,
      ST_SQUARE,
      ST_PREP,
      ST_PRODUCT,
      ST_DIVSET,
      ST_DIVIDE,
      ST_ROOT,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic [11:0] point_index;
      logic [7:0]  obs_chan_0;
      logic [7:0]  obs_chan_1;
      logic [7:0]  obs_chan_2;
      logic [23:0] obs_sigma_0;
      logic [23:0] obs_sigma_1;
      logic [23:0] obs_sigma_2;
      logic [15:0] view_distance;
      logic [31:0] obs_timestamp;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [23:0] est_chan_0;
      logic [23:0] est_chan_1;
      logic [23:0] est_chan_2;
      logic [23:0] est_sigma_0;
      logic [23:0] est_sigma_1;
      logic [23:0] est_sigma_2;
      logic [15:0] view_count;
      logic [15:0] best_distance;
   } rsp_type;

   typedef struct packed {
      logic [CHANNELS-1:0][23:0] color;
      logic [CHANNELS-1:0][23:0] sigma;
      logic [15:0]               best_dist;
      logic [31:0]               stamp;
      logic [15:0]               count;
   } entry_type;

   typedef struct packed {
      logic load;
      logic square;
      logic prep;
      logic product;
      logic divset;
      logic divide;
      logic root;
   } lane_ctrl_type;

endpackage

FILE: src/point_color_variance_fusion_core.sv
// Channel  Ports                          Moves
// req      req_valid/req_ready/req_data   one observation of a map point
// rsp      rsp_valid/rsp_ready/rsp_data   status and point state after the step
// csr      csr_valid/csr_ready/csr_index  register write, csr_data holds the value
//
// After reset a clearing pass writes every point entry before the first
// observation is taken; csr writes are taken throughout.
// A rejected or first observation goes from the decision straight to the
// write. A fused one runs a serial growth multiply, then per channel (three
// lanes in parallel) squaring, products, division and square root, one bit
// or one root digit per cycle.
// One observation is in work at a time; the result register lets the next
// observation be accepted while a result waits on rsp_ready.
module point_color_variance_fusion_core #(
   parameter int POINT_COUNT = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  pcvf_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output pcvf_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pcvf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pcvf_pkg::CSR_DATA_W-1:0]    csr_data
);
   import pcvf_pkg::*;

   localparam int AW = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;
   localparam int RW = (AW + 1 > 13) ? AW + 1 : 13;
   localparam int EW = $bits(entry_type);

   state_type state_ff, state_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [RW-1:0]  red_ff, red_in;
   logic [11:0]    idx_sr_ff, idx_sr_in;
   req_type        req_ff, req_in;
   entry_type      entry_ff, entry_in, fresh_ff, fresh_in;
   status_type     status_ff, status_in;
   logic [9:0]     gate_ff, gate_in;
   logic [23:0]    noise_ff, noise_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   lane_ctrl_type  lane_ctrl;
   logic           grow_load, grow_step;
   logic [47:0]    growth;
   logic [31:0]    elapsed;
   logic           ram_we;
   logic [AW-1:0]  ram_waddr;
   logic [EW-1:0]  ram_wdata;
   entry_type      rdata;
   entry_type      result;
   logic           done_phase;
   logic           out_free;
   logic           reject;
   logic [25:0]    gate_lhs, gate_rhs;
   logic [RW-1:0]  red_t;
   logic [CHANNELS-1:0][23:0] est_new, sigma_new, osig_vec;
   logic [CHANNELS-1:0][7:0]  obs_chan;

   pcvf_ram #(.WIDTH(EW), .DEPTH(POINT_COUNT)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (red_ff[AW-1:0]),
      .rdata (rdata)
   );

   pcvf_growth u_growth (
      .clock      (clock),
      .load       (grow_load),
      .step       (grow_step),
      .noise_rate (noise_ff),
      .elapsed    (elapsed),
      .growth     (growth)
   );

   assign obs_chan = {req_ff.obs_chan_2, req_ff.obs_chan_1, req_ff.obs_chan_0};
   assign osig_vec = {req_ff.obs_sigma_2, req_ff.obs_sigma_1, req_ff.obs_sigma_0};

   for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
      pcvf_lane u_lane (
         .clock      (clock),
         .ctrl       (lane_ctrl),
         .sigma_old  (entry_ff.sigma[k]),
         .growth     (growth),
         .meas_sigma (osig_vec[k]),
         .est_old    (entry_ff.color[k]),
         .chan       (obs_chan[k]),
         .est_new    (est_new[k]),
         .sigma_new  (sigma_new[k])
      );
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign elapsed  = (req_ff.obs_timestamp >= rdata.stamp) ?
                     (req_ff.obs_timestamp - rdata.stamp) : 32'd0;
   assign gate_lhs = {2'b00, req_ff.view_distance, 8'd0};
   assign gate_rhs = {16'd0, gate_ff} * {10'd0, rdata.best_dist};
   assign reject   = (rdata.best_dist != 16'd0) && (gate_lhs > gate_rhs);
   assign red_t    = {red_ff[RW-2:0], idx_sr_ff[11]};

   always_comb begin
      unique case (state_ff)
         ST_REDUCE:  done_phase = (cnt_ff == LAST_REDUCE);
         ST_GROWTH:  done_phase = (cnt_ff == LAST_GROWTH);
         ST_SQUARE:  done_phase = (cnt_ff == LAST_SQUARE);
         ST_PRODUCT: done_phase = (cnt_ff == LAST_PRODUCT);
         ST_DIVIDE:  done_phase = (cnt_ff == LAST_DIVIDE);
         ST_ROOT:    done_phase = (cnt_ff == LAST_ROOT);
         default:    done_phase = 1'b1;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:   if (clr_ff == AW'(POINT_COUNT - 1)) state_in = ST_IDLE;
         ST_IDLE:    if (req_valid) state_in = ST_REDUCE;
         ST_REDUCE:  if (done_phase) state_in = ST_READ;
         ST_READ:    state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (reject || rdata.count == 16'd0) begin
               state_in = ST_WRITE;
            end else begin
               state_in = ST_GROWTH;
            end
         end
         ST_GROWTH:  if (done_phase) state_in = ST_LOAD;
         ST_LOAD:    state_in = ST_SQUARE;
         ST_SQUARE:  if (done_phase) state_in = ST_PREP;
         ST_PREP:    state_in = ST_PRODUCT;
         ST_PRODUCT: if (done_phase) state_in = ST_DIVSET;
         ST_DIVSET:  state_in = ST_DIVIDE;
         ST_DIVIDE:  if (done_phase) state_in = ST_ROOT;
         ST_ROOT:    if (done_phase) state_in = ST_WRITE;
         ST_WRITE:   if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_CLEAR;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      req_ready         = 1'b0;
      lane_ctrl         = '0;
      grow_load         = 1'b0;
      grow_step         = 1'b0;
      ram_we            = 1'b0;
      ram_waddr         = red_ff[AW-1:0];
      ram_wdata         = result;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
         end
         ST_IDLE:    req_ready = 1'b1;
         ST_DECIDE:  grow_load = 1'b1;
         ST_GROWTH:  grow_step = 1'b1;
         ST_LOAD:    lane_ctrl.load = 1'b1;
         ST_SQUARE:  lane_ctrl.square = 1'b1;
         ST_PREP:    lane_ctrl.prep = 1'b1;
         ST_PRODUCT: lane_ctrl.product = 1'b1;
         ST_DIVSET:  lane_ctrl.divset = 1'b1;
         ST_DIVIDE:  lane_ctrl.divide = 1'b1;
         ST_ROOT:    lane_ctrl.root = 1'b1;
         ST_WRITE:   ram_we = out_free && (status_ff != STATUS_REJECT);
         default:    req_ready = 1'b0;
      endcase
   end

   always_comb begin
      if (status_ff == STATUS_FUSED) begin
         result       = entry_ff;
         result.color = est_new;
         result.sigma = sigma_new;
         if (req_ff.view_distance < entry_ff.best_dist) begin
            result.best_dist = req_ff.view_distance;
         end
         result.stamp = req_ff.obs_timestamp;
         if (entry_ff.count != 16'hFFFF) begin
            result.count = entry_ff.count + 16'd1;
         end
      end else begin
         result = fresh_ff;
      end
   end

   always_comb begin
      cnt_in       = (state_in != state_ff) ? 6'd0 : cnt_ff + 6'd1;
      clr_in       = (state_ff == ST_CLEAR) ? clr_ff + AW'(1) : clr_ff;
      red_in       = red_ff;
      idx_sr_in    = idx_sr_ff;
      req_in       = req_ff;
      entry_in     = entry_ff;
      fresh_in     = fresh_ff;
      status_in    = status_ff;
      gate_in      = gate_ff;
      noise_in     = noise_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (req_valid && req_ready) begin
         req_in    = req_data;
         red_in    = '0;
         idx_sr_in = req_data.point_index;
      end
      // Reduce the index modulo the point count, one bit per cycle.
      if (state_ff == ST_REDUCE) begin
         idx_sr_in = {idx_sr_ff[10:0], 1'b0};
         if (32'(red_t) >= 32'(POINT_COUNT)) begin
            red_in = RW'(32'(red_t) - 32'(POINT_COUNT));
         end else begin
            red_in = red_t;
         end
      end
      if (state_ff == ST_DECIDE) begin
         entry_in = rdata;
         fresh_in = rdata;
         if (reject) begin
            status_in = STATUS_REJECT;
         end else if (rdata.count == 16'd0) begin
            status_in = STATUS_FIRST;
            for (int k = 0; k < CHANNELS; k++) begin
               fresh_in.color[k] = {obs_chan[k], 16'd0};
               fresh_in.sigma[k] = (osig_vec[k] == 24'd0) ? 24'd1 : osig_vec[k];
            end
            fresh_in.best_dist = req_ff.view_distance;
            fresh_in.stamp     = req_ff.obs_timestamp;
            fresh_in.count     = 16'd1;
         end else begin
            status_in = STATUS_FUSED;
         end
      end
      if (state_ff == ST_WRITE && out_free) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = status_ff;
         rsp_in.est_chan_0    = result.color[0];
         rsp_in.est_chan_1    = result.color[1];
         rsp_in.est_chan_2    = result.color[2];
         rsp_in.est_sigma_0   = result.sigma[0];
         rsp_in.est_sigma_1   = result.sigma[1];
         rsp_in.est_sigma_2   = result.sigma[2];
         rsp_in.view_count    = result.count;
         rsp_in.best_distance = result.best_dist;
      end
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GATE_RATIO: gate_in  = csr_data[9:0];
            CSR_NOISE_RATE: noise_in = csr_data[23:0];
            default:        gate_in  = gate_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= 6'd0;
         clr_ff       <= '0;
         gate_ff      <= GATE_RATIO_RESET;
         noise_ff     <= NOISE_RATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         gate_ff      <= gate_in;
         noise_ff     <= noise_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      red_ff    <= red_in;
      idx_sr_ff <= idx_sr_in;
      req_ff    <= req_in;
      entry_ff  <= entry_in;
      fresh_ff  <= fresh_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: src/pcvf_ram.sv
module pcvf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
   output logic [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/pcvf_growth.sv
module pcvf_growth (
   input  logic        clock,
   input  logic        load,
   input  logic        step,
   input  logic [23:0] noise_rate,
   input  logic [31:0] elapsed,
   output logic [47:0] growth
);
   import pcvf_pkg::*;

   logic [55:0] mcand_ff, mcand_in;
   logic [31:0] mplier_ff, mplier_in;
   logic [55:0] acc_ff, acc_in;

   // Shift-add multiply, one bit of the elapsed time per cycle. The
   // accumulator starts at the rounding constant.
   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      if (load) begin
         mcand_in  = {32'd0, noise_rate};
         mplier_in = elapsed;
         acc_in    = 56'd128;
      end else if (step) begin
         acc_in    = acc_ff + (mplier_ff[0] ? mcand_ff : 56'd0);
         mcand_in  = {mcand_ff[54:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[31:1]};
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign growth = acc_ff[55:8];

endmodule

FILE: src/pcvf_lane.sv
module pcvf_lane (
   input  logic                    clock,
   input  pcvf_pkg::lane_ctrl_type ctrl,
   input  logic [23:0]             sigma_old,
   input  logic [47:0]             growth,
   input  logic [23:0]             meas_sigma,
   input  logic [23:0]             est_old,
   input  logic [7:0]              chan,
   output logic [23:0]             est_new,
   output logic [23:0]             sigma_new
);
   import pcvf_pkg::*;

   logic [47:0] sa_ff, sa_in, oa_ff, oa_in;
   logic [23:0] sb_ff, sb_in, ob_ff, ob_in;
   logic [47:0] ss_ff, ss_in, oo_ff, oo_in;
   logic [23:0] m_ff, m_in;
   logic [7:0]  c_ff, c_in;
   logic [48:0] den_ff, den_in;
   logic [73:0] n1_ff, n1_in;
   logic [95:0] n2_ff, n2_in;
   logic [71:0] msh_ff, msh_in, csh_ff, csh_in;
   logic [95:0] ssh_ff, ssh_in;
   logic [47:0] oosr_ff, oosr_in, sssr_ff, sssr_in;
   logic [49:0] rem1_ff, rem1_in, rem2_ff, rem2_in;
   logic [47:0] lo1_ff, lo1_in, lo2_ff, lo2_in;
   logic [47:0] q1_ff, q1_in, q2_ff, q2_in;
   logic [25:0] rrem_ff, rrem_in;
   logic [23:0] root_ff, root_in;

   logic [48:0] s_sum;
   logic [23:0] s_val, o_val;
   logic [49:0] t1, t2;
   logic [27:0] rt, rtrial;
   logic [24:0] rounded;

   always_comb begin
      s_sum = {1'b0, growth} + {25'd0, sigma_old};
      s_val = (s_sum[48:24] != 25'd0) ? 24'hFFFFFF : s_sum[23:0];
      if (s_val == 24'd0) begin
         s_val = 24'd1;
      end
      o_val = (meas_sigma == 24'd0) ? 24'd1 : meas_sigma;
      t1     = {rem1_ff[48:0], lo1_ff[47]};
      t2     = {rem2_ff[48:0], lo2_ff[47]};
      rt     = {rrem_ff, q2_ff[47:46]};
      rtrial = {2'b00, root_ff, 2'b01};
   end

   always_comb begin
      sa_in = sa_ff;  sb_in = sb_ff;  oa_in = oa_ff;  ob_in = ob_ff;
      ss_in = ss_ff;  oo_in = oo_ff;  m_in = m_ff;    c_in = c_ff;
      den_in = den_ff; n1_in = n1_ff; n2_in = n2_ff;
      msh_in = msh_ff; csh_in = csh_ff; ssh_in = ssh_ff;
      oosr_in = oosr_ff; sssr_in = sssr_ff;
      rem1_in = rem1_ff; rem2_in = rem2_ff; lo1_in = lo1_ff; lo2_in = lo2_ff;
      q1_in = q1_ff; q2_in = q2_ff; rrem_in = rrem_ff; root_in = root_ff;
      if (ctrl.load) begin
         sa_in = {24'd0, s_val};
         sb_in = s_val;
         oa_in = {24'd0, o_val};
         ob_in = o_val;
         ss_in = 48'd0;
         oo_in = 48'd0;
         m_in  = est_old;
         c_in  = chan;
      end
      if (ctrl.square) begin
         ss_in = ss_ff + (sb_ff[0] ? sa_ff : 48'd0);
         oo_in = oo_ff + (ob_ff[0] ? oa_ff : 48'd0);
         sa_in = {sa_ff[46:0], 1'b0};
         oa_in = {oa_ff[46:0], 1'b0};
         sb_in = {1'b0, sb_ff[23:1]};
         ob_in = {1'b0, ob_ff[23:1]};
      end
      if (ctrl.prep) begin
         den_in  = {1'b0, ss_ff} + {1'b0, oo_ff};
         n1_in   = {26'd0, den_in[48:1]};
         n2_in   = {48'd0, den_in[48:1]};
         msh_in  = {48'd0, m_ff};
         csh_in  = {48'd0, c_ff, 16'd0};
         ssh_in  = {48'd0, ss_ff};
         oosr_in = oo_ff;
         sssr_in = ss_ff;
      end
      if (ctrl.product) begin
         n1_in   = n1_ff + {2'b00, (oosr_ff[0] ? msh_ff : 72'd0)}
                         + {2'b00, (sssr_ff[0] ? csh_ff : 72'd0)};
         n2_in   = n2_ff + (oosr_ff[0] ? ssh_ff : 96'd0);
         msh_in  = {msh_ff[70:0], 1'b0};
         csh_in  = {csh_ff[70:0], 1'b0};
         ssh_in  = {ssh_ff[94:0], 1'b0};
         oosr_in = {1'b0, oosr_ff[47:1]};
         sssr_in = {1'b0, sssr_ff[47:1]};
      end
      if (ctrl.divset) begin
         // Both quotients stay below 2^48, so the upper part of each
         // numerator is already below the divisor.
         rem1_in = {24'd0, n1_ff[73:48]};
         rem2_in = {2'b00, n2_ff[95:48]};
         lo1_in  = n1_ff[47:0];
         lo2_in  = n2_ff[47:0];
         q1_in   = 48'd0;
         q2_in   = 48'd0;
         rrem_in = 26'd0;
         root_in = 24'd0;
      end
      if (ctrl.divide) begin
         lo1_in = {lo1_ff[46:0], 1'b0};
         lo2_in = {lo2_ff[46:0], 1'b0};
         if (t1 >= {1'b0, den_ff}) begin
            rem1_in = t1 - {1'b0, den_ff};
            q1_in   = {q1_ff[46:0], 1'b1};
         end else begin
            rem1_in = t1;
            q1_in   = {q1_ff[46:0], 1'b0};
         end
         if (t2 >= {1'b0, den_ff}) begin
            rem2_in = t2 - {1'b0, den_ff};
            q2_in   = {q2_ff[46:0], 1'b1};
         end else begin
            rem2_in = t2;
            q2_in   = {q2_ff[46:0], 1'b0};
         end
      end
      if (ctrl.root) begin
         q2_in = {q2_ff[45:0], 2'b00};
         if (rt >= rtrial) begin
            rrem_in = 26'(rt - rtrial);
            root_in = {root_ff[22:0], 1'b1};
         end else begin
            rrem_in = rt[25:0];
            root_in = {root_ff[22:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      sa_ff <= sa_in;  sb_ff <= sb_in;  oa_ff <= oa_in;  ob_ff <= ob_in;
      ss_ff <= ss_in;  oo_ff <= oo_in;  m_ff <= m_in;    c_ff <= c_in;
      den_ff <= den_in; n1_ff <= n1_in; n2_ff <= n2_in;
      msh_ff <= msh_in; csh_ff <= csh_in; ssh_ff <= ssh_in;
      oosr_ff <= oosr_in; sssr_ff <= sssr_in;
      rem1_ff <= rem1_in; rem2_ff <= rem2_in; lo1_ff <= lo1_in; lo2_ff <= lo2_in;
      q1_ff <= q1_in; q2_ff <= q2_in; rrem_ff <= rrem_in; root_ff <= root_in;
   end

   // The root remainder equals v minus root squared; round half up.
   always_comb begin
      est_new = (q1_ff[47:24] != 24'd0) ? 24'hFFFFFF : q1_ff[23:0];
      rounded = {1'b0, root_ff} + {24'd0, (rrem_ff > {2'b00, root_ff})};
      sigma_new = rounded[24] ? 24'hFFFFFF : rounded[23:0];
      if (sigma_new == 24'd0) begin
         sigma_new = 24'd1;
      end
   end

endmodule
